>>> hw/rtl/hdu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdu_pkg
// Shared types and constants of the half-duplex 8N1 UART.
// ----------------------------------------------------------------------------
package hdu_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TICKS          = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SAMPLE_TICKS = 1'd1;

    localparam logic [15:0] BIT_TICKS_RESET          = 16'd104;
    localparam logic [15:0] FIRST_SAMPLE_TICKS_RESET = 16'd156;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_TX   = 3'd1;
    localparam logic [2:0] MODE_STOP = 3'd2;
    localparam logic [2:0] MODE_RX   = 3'd3;
    localparam logic [2:0] MODE_PEND = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TX   = 5'b00010,
        ST_STOP = 5'b00100,
        ST_RX   = 5'b01000,
        ST_PEND = 5'b10000
    } state_t;

    typedef struct packed {
        logic       rx_level;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       take;
    } in_t;

    typedef struct packed {
        logic       tx_level;
        logic [2:0] mode;
        logic       send_accepted;
        logic [7:0] rx_byte;
        logic       rx_pending;
    } out_t;

    typedef struct packed {
        state_t      mode;
        logic [15:0] bit_timer;
        logic [7:0]  tx_shift;
        logic [3:0]  tx_count;
        logic [7:0]  rx_shift;
        logic [3:0]  rx_count;
        logic        prev_rx;
        logic        tx_line;
    } uart_state_t;

    typedef struct packed {
        logic [15:0] bit_ticks;
        logic [15:0] first_sample_ticks;
    } cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/hdu_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdu_step
// Next-state and result logic for one timer tick.
// ----------------------------------------------------------------------------
module hdu_step (
    input  var hdu_pkg::uart_state_t cur,
    input  var hdu_pkg::cfg_t        cfg,
    input  var hdu_pkg::in_t         req,
    output hdu_pkg::uart_state_t     nxt,
    output hdu_pkg::out_t            res
);

    function automatic logic [15:0] period_of(input logic [15:0] v);
        begin
            period_of = (v == 16'd0) ? 16'd1 : v;
        end
    endfunction

    hdu_pkg::state_t      mode_take;
    logic                 start_edge;
    logic [15:0]          timer_dec;
    logic                 accepted;
    hdu_pkg::uart_state_t s;

    always_comb
    begin
        s          = cur;
        accepted   = 1'b0;
        mode_take  = (req.take && cur.mode == hdu_pkg::ST_PEND) ? hdu_pkg::ST_IDLE : cur.mode;
        start_edge = cur.prev_rx && !req.rx_level;
        timer_dec  = cur.bit_timer - 16'd1;
        s.mode     = mode_take;

        if ((mode_take == hdu_pkg::ST_IDLE || mode_take == hdu_pkg::ST_PEND) && start_edge)
        begin
            s.mode      = hdu_pkg::ST_RX;
            s.rx_count  = 4'd0;
            s.bit_timer = period_of(cfg.first_sample_ticks);
        end
        else if (mode_take == hdu_pkg::ST_TX || mode_take == hdu_pkg::ST_STOP ||
                 mode_take == hdu_pkg::ST_RX)
        begin
            s.bit_timer = timer_dec;
            if (timer_dec == 16'd0)
            begin
                unique case (mode_take)
                    hdu_pkg::ST_TX:
                    begin
                        s.bit_timer = period_of(cfg.bit_ticks);
                        if (cur.tx_count < hdu_pkg::BITS_PER_BYTE)
                        begin
                            s.tx_line  = cur.tx_shift[0];
                            s.tx_shift = {1'b0, cur.tx_shift[7:1]};
                            s.tx_count = cur.tx_count + 4'd1;
                        end
                        else
                        begin
                            s.tx_line = 1'b1;
                            s.mode    = hdu_pkg::ST_STOP;
                        end
                    end
                    hdu_pkg::ST_STOP:
                    begin
                        s.mode = hdu_pkg::ST_IDLE;
                    end
                    hdu_pkg::ST_RX:
                    begin
                        s.bit_timer = period_of(cfg.bit_ticks);
                        if (cur.rx_count < hdu_pkg::BITS_PER_BYTE)
                        begin
                            s.rx_count = cur.rx_count + 4'd1;
                            s.rx_shift = {req.rx_level, cur.rx_shift[7:1]};
                        end
                        else
                        begin
                            s.mode = hdu_pkg::ST_PEND;
                        end
                    end
                    default:
                    begin
                        s.mode = hdu_pkg::ST_IDLE;
                    end
                endcase
            end
        end

        if (s.mode == hdu_pkg::ST_IDLE && req.send_valid)
        begin
            accepted    = 1'b1;
            s.mode      = hdu_pkg::ST_TX;
            s.tx_shift  = req.send_byte;
            s.tx_count  = 4'd0;
            s.tx_line   = 1'b0;
            s.bit_timer = period_of(cfg.bit_ticks);
        end

        s.prev_rx = req.rx_level;
    end

    always_comb
    begin
        nxt               = s;
        res.tx_level      = s.tx_line;
        res.send_accepted = accepted;
        res.rx_byte       = s.rx_shift;
        res.rx_pending    = (s.mode == hdu_pkg::ST_PEND);
        unique case (s.mode)
            hdu_pkg::ST_IDLE: res.mode = hdu_pkg::MODE_IDLE;
            hdu_pkg::ST_TX:   res.mode = hdu_pkg::MODE_TX;
            hdu_pkg::ST_STOP: res.mode = hdu_pkg::MODE_STOP;
            hdu_pkg::ST_RX:   res.mode = hdu_pkg::MODE_RX;
            hdu_pkg::ST_PEND: res.mode = hdu_pkg::MODE_PEND;
            default:          res.mode = hdu_pkg::MODE_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/half_duplex_uart_8n1.sv
`default_nettype none
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1
// Half-duplex 8N1 UART advanced by one timer tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one request per timer tick,
//   carrying the sampled rx line, an optional byte to send and a take strobe.
//   Output channel (out_valid / out_stall / out_data): one result per request
//   with tx line level, mode, send-accepted flag and receive byte status.
//   Config port (cfg_wr_en / cfg_index / cfg_data): index 0 bit_ticks,
//   index 1 first_sample_ticks; write only while idle.
//   Latency: result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle unless stalled; the tick update is one
//   logic pass from the state registers into the state and result registers.
//   Reset: mode idle, tx line and previous rx high, counters clear,
//   bit_ticks 104, first_sample_ticks 156, no result held.
//   Receiver stall: the held result stays put and in_stall is raised while
//   the result register is full and stalled.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1 (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  var hdu_pkg::in_t                    in_data,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output hdu_pkg::out_t                       out_data,
    input  wire                                 cfg_wr_en,
    input  wire  [hdu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [hdu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    hdu_pkg::uart_state_t state_reg;
    hdu_pkg::uart_state_t state_next;
    hdu_pkg::cfg_t        cfg_reg;
    hdu_pkg::out_t        out_reg;
    hdu_pkg::out_t        out_next;
    logic                 out_valid_reg;
    logic                 accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    hdu_step u_step (
        .cur (state_reg),
        .cfg (cfg_reg),
        .req (in_data),
        .nxt (state_next),
        .res (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode      <= hdu_pkg::ST_IDLE;
            state_reg.bit_timer <= 16'd0;
            state_reg.tx_shift  <= 8'd0;
            state_reg.tx_count  <= 4'd0;
            state_reg.rx_shift  <= 8'd0;
            state_reg.rx_count  <= 4'd0;
            state_reg.prev_rx   <= 1'b1;
            state_reg.tx_line   <= 1'b1;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_ticks          <= hdu_pkg::BIT_TICKS_RESET;
            cfg_reg.first_sample_ticks <= hdu_pkg::FIRST_SAMPLE_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hdu_pkg::CFG_BIT_TICKS:          cfg_reg.bit_ticks          <= cfg_data;
                hdu_pkg::CFG_FIRST_SAMPLE_TICKS: cfg_reg.first_sample_ticks <= cfg_data;
                default:                         cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire
